/* rtl/ghw_pkg.sv */
// shared beat types and constants for the gift-wrap hull core
`default_nettype none
package ghw_pkg;

  localparam int unsigned FieldBits = 16;
  localparam int unsigned IndexBits = 6;

  typedef struct packed {
    logic signed [FieldBits-1:0] point_x;
    logic signed [FieldBits-1:0] point_y;
    logic                        last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] vertex_x;
    logic signed [FieldBits-1:0] vertex_y;
    logic [IndexBits-1:0]        vertex_index;
    logic                        final_vertex;
    logic                        overflow_seen;
  } out_beat_t;

  // per-cycle commands from the sequencer to the cell row
  typedef struct packed {
    logic shift;
    logic clear;
    logic write;
  } row_ctrl_t;

endpackage
`default_nettype wire

/* rtl/convex_hull_gift_wrap_core.sv */
// top level of the gift-wrap convex hull core
`default_nettype none
// Points are loaded one per input beat into a ring of MAX_POINTS cells; on each load every
// cell checks the new point for a duplicate in parallel. A point equal to a stored one is
// dropped; a new point that finds the ring full is dropped and sets the overflow mark
// carried on every vertex of that run. The beat with last_point set is loaded first and
// then starts the walk: one rotation of the ring finds the start point, then each hull
// step rotates the ring once more, holding each cell at the head while the turn test and
// distance products are registered before they are compared, and then puts its vertex in
// the output register. One vertex beat leaves per step; a step waits to emit while an
// earlier vertex is still held, not taken, in the output register. No input beat is taken
// during a run; the last vertex may still wait in the output register while the next set
// is loading.
module convex_hull_gift_wrap_core #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ghw_pkg::in_beat_t in_beat_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ghw_pkg::out_beat_t     out_beat_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned CW = $clog2(MAX_POINTS);
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = 2 * C + 2;
  localparam int unsigned XW = 2 * C + 3;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  // sequencer registers
  logic [NW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ph_q, ph_d;
  logic          have_q, have_d;
  logic [NW-1:0] len_q, len_d;
  logic [C-1:0]  st_x_q, st_x_d, st_y_q, st_y_d;
  logic [C-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [C-1:0]  best_x_q, best_x_d, best_y_q, best_y_d;
  logic [XW-1:0] bdist_q, bdist_d;

  logic                 ov_q, ov_d;
  ghw_pkg::out_beat_t   ob_q, ob_d;

  // input point brought to the internal width
  logic [31:0]  in_x32, in_y32;
  logic [C-1:0] px, py;
  assign in_x32 = {{16{in_beat_i.point_x[15]}}, in_beat_i.point_x};
  assign in_y32 = {{16{in_beat_i.point_y[15]}}, in_beat_i.point_y};
  assign px = in_x32[C-1:0];
  assign py = in_y32[C-1:0];

  logic in_fire;
  assign in_ready_o = (state_q == S_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;

  // cell ring
  ghw_pkg::row_ctrl_t ctrl;
  logic [C-1:0]       head_x, head_y;
  logic               head_v, dup;

  ghw_cell_row #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(C)) u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .wr_idx_i(count_q[CW-1:0]),
    .wr_x_i  (px),
    .wr_y_i  (py),
    .head_x_o(head_x),
    .head_y_o(head_y),
    .head_v_o(head_v),
    .match_o (dup)
  );

  // turn and distance products, taken on the first half of each cell slot
  logic signed [PW-1:0] p_bc, p_cb, p_xx, p_yy;

  ghw_geom #(.COORD_BITS(C)) u_geom (
    .clk_i (clk_i),
    .en_i  ((state_q == S_SCAN) && !ph_q),
    .a_x_i (cur_x_q),
    .a_y_i (cur_y_q),
    .b_x_i (best_x_q),
    .b_y_i (best_y_q),
    .c_x_i (head_x),
    .c_y_i (head_y),
    .p_bc_o(p_bc),
    .p_cb_o(p_cb),
    .p_xx_o(p_xx),
    .p_yy_o(p_yy)
  );

  logic signed [XW-1:0] turn_v;
  logic [XW-1:0]        cdist;
  logic                 skip, take, last_cell, room, run_end;
  logic [NW-1:0]        idx_w;
  logic [31:0]          ox32, oy32;

  assign turn_v = {p_bc[PW-1], p_bc} - {p_cb[PW-1], p_cb};
  assign cdist = {1'b0, p_xx} + {1'b0, p_yy};
  // empty slots and the current vertex itself are not candidates
  assign skip  = !head_v || ((head_x == cur_x_q) && (head_y == cur_y_q));
  // the first candidate, or one clockwise of best, or collinear and strictly farther
  assign take  = !have_q || (turn_v < 0) || ((turn_v == 0) && (cdist > bdist_q));
  assign last_cell = (cnt_q == CW'(MAX_POINTS - 1));
  assign room  = !ov_q || out_ready_i;
  // walk closes on no candidate, back at the start, or after count vertices
  assign run_end = !have_q || ((best_x_q == st_x_q) && (best_y_q == st_y_q))
                   || (len_q >= count_q);
  assign idx_w = len_q - NW'(1);
  assign ox32  = {{(32 - C){cur_x_q[C-1]}}, cur_x_q};
  assign oy32  = {{(32 - C){cur_y_q[C-1]}}, cur_y_q};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    have_d   = have_q;
    len_d    = len_q;
    st_x_d   = st_x_q;
    st_y_d   = st_y_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    best_x_d = best_x_q;
    best_y_d = best_y_q;
    bdist_d  = bdist_q;
    ov_d     = ov_q;
    ob_d     = ob_q;
    ctrl     = '0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (!dup) begin
            if (count_q == NW'(MAX_POINTS)) begin
              ovf_d = 1'b1;
            end else begin
              ctrl.write = 1'b1;
              count_d    = count_q + NW'(1);
            end
          end
          if (in_beat_i.last_point) begin
            state_d = S_START;
            cnt_d   = '0;
            have_d  = 1'b0;
          end
        end
      end
      S_START: begin
        // greatest x, least y among ties, first in load order
        ctrl.shift = 1'b1;
        if (head_v && (!have_q || ($signed(head_x) > $signed(st_x_q)) ||
            ((head_x == st_x_q) && ($signed(head_y) < $signed(st_y_q))))) begin
          st_x_d = head_x;
          st_y_d = head_y;
          have_d = 1'b1;
        end
        cnt_d = cnt_q + CW'(1);
        if (last_cell) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          ph_d    = 1'b0;
          have_d  = 1'b0;
          len_d   = NW'(1);
          cur_x_d = st_x_d;
          cur_y_d = st_y_d;
        end
      end
      S_SCAN: begin
        ph_d = !ph_q;
        if (ph_q) begin
          ctrl.shift = 1'b1;
          if (!skip && take) begin
            best_x_d = head_x;
            best_y_d = head_y;
            bdist_d  = cdist;
            have_d   = 1'b1;
          end
          cnt_d = cnt_q + CW'(1);
          if (last_cell) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (room) begin
          ov_d                = 1'b1;
          ob_d.vertex_x       = ox32[15:0];
          ob_d.vertex_y       = oy32[15:0];
          ob_d.vertex_index   = idx_w[ghw_pkg::IndexBits-1:0];
          ob_d.final_vertex   = run_end;
          ob_d.overflow_seen  = ovf_q;
          if (run_end) begin
            state_d    = S_LOAD;
            ctrl.clear = 1'b1;
            count_d    = '0;
            ovf_d      = 1'b0;
          end else begin
            state_d = S_SCAN;
            cur_x_d = best_x_q;
            cur_y_d = best_y_q;
            len_d   = len_q + NW'(1);
            have_d  = 1'b0;
            cnt_d   = '0;
            ph_d    = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      ph_q    <= 1'b0;
      have_q  <= 1'b0;
      len_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      have_q  <= have_d;
      len_q   <= len_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_x_q   <= st_x_d;
    st_y_q   <= st_y_d;
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    best_x_q <= best_x_d;
    best_y_q <= best_y_d;
    bdist_q  <= bdist_d;
    ob_q     <= ob_d;
  end

  assign out_valid_o = ov_q;
  assign out_beat_o  = ob_q;

endmodule
`default_nettype wire

/* rtl/ghw_cell.sv */
// one storage cell of the point ring: holds a point and its valid bit
`default_nettype none
module ghw_cell #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ghw_pkg::row_ctrl_t    ctrl_i,
  input  wire logic                  wr_sel_i,
  input  wire logic [COORD_BITS-1:0] wr_x_i,
  input  wire logic [COORD_BITS-1:0] wr_y_i,
  input  wire logic [COORD_BITS-1:0] nb_x_i,
  input  wire logic [COORD_BITS-1:0] nb_y_i,
  input  wire logic                  nb_v_i,
  output logic      [COORD_BITS-1:0] x_o,
  output logic      [COORD_BITS-1:0] y_o,
  output logic                       v_o,
  output logic                       match_o
);

  logic [COORD_BITS-1:0] x_q, y_q;
  logic                  v_q;
  logic                  wr_en;

  assign wr_en = ctrl_i.write && wr_sel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      v_q <= 1'b0;
    end else if (wr_en) begin
      v_q <= 1'b1;
    end else if (ctrl_i.shift) begin
      v_q <= nb_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end else if (ctrl_i.shift) begin
      x_q <= nb_x_i;
      y_q <= nb_y_i;
    end
  end

  assign x_o     = x_q;
  assign y_o     = y_q;
  assign v_o     = v_q;
  assign match_o = v_q && (x_q == wr_x_i) && (y_q == wr_y_i);

endmodule
`default_nettype wire

/* rtl/ghw_cell_row.sv */
// ring of point cells, rotating toward cell zero on shift
`default_nettype none
module ghw_cell_row #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ghw_pkg::row_ctrl_t            ctrl_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_idx_i,
  input  wire logic [COORD_BITS-1:0]         wr_x_i,
  input  wire logic [COORD_BITS-1:0]         wr_y_i,
  output logic      [COORD_BITS-1:0]         head_x_o,
  output logic      [COORD_BITS-1:0]         head_y_o,
  output logic                               head_v_o,
  output logic                               match_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS);

  logic [COORD_BITS-1:0] cx [MAX_POINTS];
  logic [COORD_BITS-1:0] cy [MAX_POINTS];
  logic [MAX_POINTS-1:0] cv;
  logic [MAX_POINTS-1:0] cm;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int unsigned Nb = (i + 1) % MAX_POINTS;
    ghw_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .wr_sel_i(wr_idx_i == CW'(i)),
      .wr_x_i  (wr_x_i),
      .wr_y_i  (wr_y_i),
      .nb_x_i  (cx[Nb]),
      .nb_y_i  (cy[Nb]),
      .nb_v_i  (cv[Nb]),
      .x_o     (cx[i]),
      .y_o     (cy[i]),
      .v_o     (cv[i]),
      .match_o (cm[i])
    );
  end

  assign head_x_o = cx[0];
  assign head_y_o = cy[0];
  assign head_v_o = cv[0];
  assign match_o  = |cm;

endmodule
`default_nettype wire

/* rtl/ghw_geom.sv */
// registered products for the turn test and squared distance
`default_nettype none
module ghw_geom #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [COORD_BITS-1:0]          a_x_i,
  input  wire logic [COORD_BITS-1:0]          a_y_i,
  input  wire logic [COORD_BITS-1:0]          b_x_i,
  input  wire logic [COORD_BITS-1:0]          b_y_i,
  input  wire logic [COORD_BITS-1:0]          c_x_i,
  input  wire logic [COORD_BITS-1:0]          c_y_i,
  output logic signed [2*COORD_BITS+1:0]      p_bc_o,
  output logic signed [2*COORD_BITS+1:0]      p_cb_o,
  output logic signed [2*COORD_BITS+1:0]      p_xx_o,
  output logic signed [2*COORD_BITS+1:0]      p_yy_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;

  logic signed [DW-1:0] bx, by, cx, cy;
  logic signed [PW-1:0] p_bc_d, p_cb_d, p_xx_d, p_yy_d;

  assign bx = {b_x_i[COORD_BITS-1], b_x_i} - {a_x_i[COORD_BITS-1], a_x_i};
  assign by = {b_y_i[COORD_BITS-1], b_y_i} - {a_y_i[COORD_BITS-1], a_y_i};
  assign cx = {c_x_i[COORD_BITS-1], c_x_i} - {a_x_i[COORD_BITS-1], a_x_i};
  assign cy = {c_y_i[COORD_BITS-1], c_y_i} - {a_y_i[COORD_BITS-1], a_y_i};

  assign p_bc_d = bx * cy;
  assign p_cb_d = by * cx;
  assign p_xx_d = cx * cx;
  assign p_yy_d = cy * cy;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_bc_o <= p_bc_d;
      p_cb_o <= p_cb_d;
      p_xx_o <= p_xx_d;
      p_yy_o <= p_yy_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/ghw_checker.sv */
// port-level checks for the gift-wrap hull core, bound to the top level
`default_nettype none
module ghw_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire ghw_pkg::in_beat_t  in_beat_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire ghw_pkg::out_beat_t out_beat_o
);

  // a waiting point beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_beat_i))
    else $error("point beat changed while waiting");

  // a stalled vertex beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("vertex beat changed while stalled");

  // no point is taken while a walk still has vertices to give
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.final_vertex |-> !in_ready_o)
    else $error("input ready during a walk");

  // a walk ends only by handing out its final vertex
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && out_beat_o.final_vertex)
    else $error("walk ended without a final vertex");

endmodule

bind convex_hull_gift_wrap_core ghw_checker u_ghw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_beat_i  (in_beat_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_beat_o (out_beat_o)
);
`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for the gift-wrap convex hull core
`timescale 1ns / 1ps
module tb;

  localparam int NPTS = 64;
  localparam int LIMIT_CYCLES = 4000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  ghw_pkg::in_beat_t  in_beat_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  ghw_pkg::out_beat_t out_beat_o;

  convex_hull_gift_wrap_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_beat_o(out_beat_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: the stored point set
  logic signed [15:0] pts_x [NPTS];
  logic signed [15:0] pts_y [NPTS];
  int                 pts_n = 0;
  bit                 pts_ovf = 0;
  ghw_pkg::out_beat_t vertex_q [$];
  int                 errors = 0;
  int unsigned        cycles = 0;
  bit                 hold_off = 0;

  function automatic longint cross_sign(int a, int b, int c);
    longint bx, by, cx, cy, v;
    bx = longint'(pts_x[b]) - pts_x[a];
    by = longint'(pts_y[b]) - pts_y[a];
    cx = longint'(pts_x[c]) - pts_x[a];
    cy = longint'(pts_y[c]) - pts_y[a];
    v = bx * cy - by * cx;
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint sq_dist(int a, int b);
    longint dx, dy;
    dx = longint'(pts_x[a]) - pts_x[b];
    dy = longint'(pts_y[a]) - pts_y[b];
    return dx * dx + dy * dy;
  endfunction

  // load one point and, on the last one, wrap the hull into vertex_q
  task automatic predict_hull(ghw_pkg::in_beat_t b);
    int                 walk [NPTS];
    int                 len, cur, best, start;
    bit                 closed, have, dup;
    longint             t;
    ghw_pkg::out_beat_t v;
    dup = 0;
    for (int i = 0; i < pts_n; i++)
      if (pts_x[i] == b.point_x && pts_y[i] == b.point_y) dup = 1;
    if (!dup) begin
      if (pts_n >= NPTS) begin
        pts_ovf = 1;
      end else begin
        pts_x[pts_n] = b.point_x;
        pts_y[pts_n] = b.point_y;
        pts_n++;
      end
    end
    if (!b.last_point) return;
    start = 0;
    for (int i = 1; i < pts_n; i++)
      if (pts_x[i] > pts_x[start] || (pts_x[i] == pts_x[start] && pts_y[i] < pts_y[start]))
        start = i;
    cur = start;
    len = 0;
    closed = 0;
    while (!closed && len < pts_n) begin
      walk[len] = cur;
      len++;
      best = cur;
      have = 0;
      for (int i = 0; i < pts_n; i++) begin
        if (i == cur) continue;
        if (!have) begin
          best = i;
          have = 1;
          continue;
        end
        t = cross_sign(cur, best, i);
        if (t < 0 || (t == 0 && sq_dist(cur, i) > sq_dist(cur, best))) best = i;
      end
      if (!have) break;
      cur = best;
      if (cur == start) closed = 1;
    end
    for (int k = 0; k < len; k++) begin
      v.vertex_x = pts_x[walk[k]];
      v.vertex_y = pts_y[walk[k]];
      v.vertex_index = k[5:0];
      v.final_vertex = (k + 1 == len);
      v.overflow_seen = pts_ovf;
      vertex_q.push_back(v);
    end
    pts_n = 0;
    pts_ovf = 0;
  endtask

  // send one point beat, with a random gap before it; valid stays up after the
  // handshake until the next beat or an explicit idle
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
    ghw_pkg::in_beat_t b;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    b.point_x = x;
    b.point_y = y;
    b.last_point = last;
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_hull(b);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (vertex_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  // check each vertex beat against the oldest prediction
  always @(posedge clk_i) begin
    ghw_pkg::out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex beat x=%0d y=%0d", out_beat_o.vertex_x, out_beat_o.vertex_y);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (out_beat_o.vertex_x !== e.vertex_x) begin
          $error("vertex_x exp %0d got %0d", e.vertex_x, out_beat_o.vertex_x); errors++;
        end
        if (out_beat_o.vertex_y !== e.vertex_y) begin
          $error("vertex_y exp %0d got %0d", e.vertex_y, out_beat_o.vertex_y); errors++;
        end
        if (out_beat_o.vertex_index !== e.vertex_index) begin
          $error("vertex_index exp %0d got %0d", e.vertex_index, out_beat_o.vertex_index);
          errors++;
        end
        if (out_beat_o.final_vertex !== e.final_vertex) begin
          $error("final_vertex exp %0d got %0d", e.final_vertex, out_beat_o.final_vertex);
          errors++;
        end
        if (out_beat_o.overflow_seen !== e.overflow_seen) begin
          $error("overflow_seen exp %0d got %0d", e.overflow_seen, out_beat_o.overflow_seen);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // directed: extremes, duplicates, single point, collinear sets
  task automatic test_directed();
    send_point(16'sd5, -16'sd3, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b1);
    send_point(16'sd7, 16'sd7, 1'b0);
    send_point(16'sd7, 16'sd7, 1'b1);
    send_point(-16'sd1, 16'sd4, 1'b0);
    send_point(-16'sd1, -16'sd4, 1'b0);
    send_point(-16'sd1, 16'sd0, 1'b1);
    wait_drained();
  endtask

  // one random set of n points, clustered or full range
  task automatic send_set(int n, bit wide);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = $signed(16'($urandom_range(0, 12))) - 16'sd6;
        y = $signed(16'($urandom_range(0, 12))) - 16'sd6;
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    while (sent < 220) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_set(n, $urandom_range(0, 1));
      sent += n;
    end
  endtask

  // fill past capacity so overflow shows on the vertices
  task automatic test_overflow();
    for (int i = 0; i < 70; i++)
      send_point(16'(i * 97 - 3000), 16'(i * i - 1500), i == 69);
  endtask

  // hold the output off while further sets are offered
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        send_set(6, 1'b1);
        send_set(5, 1'b0);
        send_set(4, 1'b1);
        idle_input();
      end
    join
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random_sets();
    wait_drained();
    repeat (500) @(posedge clk_i);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
